// ===== hw/rtl/mpsra_pkg.sv =====
package mpsra_pkg;

   // Widest padded dimension a page can hold (PAGE_SIZE up to 4096).
   localparam int DIM_W = 13;
   // Widest page number carried along the chain (up to 64 pages).
   localparam int PAGE_W = 6;
   // Width of a requested dimension and of the padded sum before the size check.
   localparam int RECT_W = 11;
   localparam int PSUM_W = 12;
   // Widths of the result fields.
   localparam int POS_W = 10;
   localparam int PIDX_W = 3;
   localparam int TOTAL_W = 24;

   // Result status codes.
   localparam logic [1:0] STATUS_PLACED = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_TOO_BIG = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_HOLD
   } state_type;

   // Request token that walks the row of page cells.
   typedef struct packed {
      logic              valid;
      logic              done;
      logic [DIM_W-1:0]  pw;
      logic [DIM_W-1:0]  ph;
      logic [PAGE_W-1:0] page;
      logic [POS_W-1:0]  px;
      logic [POS_W-1:0]  py;
   } token_type;

endpackage

// ===== hw/rtl/mpsra_cell.sv =====
module mpsra_cell #(
   parameter int PAGE_SIZE = 1024,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [3:0]            pad,
   input  mpsra_pkg::token_type  tok_in,
   output mpsra_pkg::token_type  tok_out
);

   localparam int CW = $clog2(PAGE_SIZE + 1);
   localparam int XW = (CW + 1 > mpsra_pkg::POS_W) ? CW + 1 : mpsra_pkg::POS_W;
   localparam int PGW = mpsra_pkg::PAGE_W;
   localparam logic [CW:0] LIMIT = (CW + 1)'(PAGE_SIZE);

   logic [CW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] top_ff, top_in;
   logic [CW-1:0] tall_ff, tall_in;
   mpsra_pkg::token_type tok_ff, tok_in_next;

   logic          attempt;
   logic [CW-1:0] pw_c, ph_c;
   logic          shelf_ok, page_ok;
   logic [CW-1:0] cur0, top0, tall0;
   logic [XW-1:0] px_sum, py_sum;

   // Page attempt: close the shelf if the item runs past the right edge,
   // then check whether its height fits from the top of the current shelf.
   always_comb begin
      attempt = tok_in.valid && !tok_in.done;
      pw_c = tok_in.pw[CW-1:0];
      ph_c = tok_in.ph[CW-1:0];
      shelf_ok = ({1'b0, cursor_ff} + {1'b0, pw_c}) <= LIMIT;
      cur0 = shelf_ok ? cursor_ff : '0;
      top0 = shelf_ok ? top_ff : CW'({1'b0, top_ff} + {1'b0, tall_ff});
      tall0 = shelf_ok ? tall_ff : '0;
      page_ok = ({1'b0, top0} + {1'b0, ph_c}) <= LIMIT;
      px_sum = XW'(cur0) + XW'(pad);
      py_sum = XW'(top0) + XW'(pad);
   end

   // Next page state and outgoing token.
   always_comb begin
      cursor_in = cursor_ff;
      top_in = top_ff;
      tall_in = tall_ff;
      tok_in_next = tok_in;
      if (attempt) begin
         top_in = top0;
         cursor_in = page_ok ? CW'({1'b0, cur0} + {1'b0, pw_c}) : cur0;
         tall_in = (page_ok && (ph_c > tall0)) ? ph_c : tall0;
         if (page_ok) begin
            tok_in_next.done = 1'b1;
            tok_in_next.page = PGW'(INDEX);
            tok_in_next.px = px_sum[mpsra_pkg::POS_W-1:0];
            tok_in_next.py = py_sum[mpsra_pkg::POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         top_ff <= '0;
         tall_ff <= '0;
         tok_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
         top_ff <= top_in;
         tall_ff <= tall_in;
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== hw/rtl/multi_page_shelf_rect_allocator.sv =====
// Shelf-packing rectangle allocator over up to MAX_PAGES square pages of
// PAGE_SIZE pixels. Each request item carries a width and height; the block
// grows it by edge_padding on every side, tries the open pages first-fit in
// index order and opens a new page when none fits. Each page is one cell in
// a row; the request walks the row one cell per cycle, and the controller
// registers the result when the token leaves the last cell. An empty or
// oversized request is answered from the check state without entering the
// row. One request is in progress at a time; a finished result sits in the
// output register while the next request is taken. The user must write the
// padding register on the csr port only while the block is idle; the block
// itself does not enforce it.
module multi_page_shelf_rect_allocator #(
   parameter int PAGE_SIZE = 1024,
   parameter int MAX_PAGES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rect_width [10:0], rect_height [21:11], zero [23:22]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // page_index [2:0], place_x [12:3], place_y [22:13],
   // total_used_area [46:23], zero [47]
   output logic [47:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   // edge_padding [3:0], zero [7:4]
   input  logic [7:0]  csr_tdata
);

   localparam int DW = mpsra_pkg::DIM_W;
   localparam int RW = mpsra_pkg::RECT_W;
   localparam int SW = mpsra_pkg::PSUM_W;
   localparam int TW = mpsra_pkg::TOTAL_W;
   localparam logic [SW:0] LIMIT = (SW + 1)'(PAGE_SIZE);

   mpsra_pkg::state_type state_ff, state_in;

   logic [3:0]    pad_ff;
   logic [RW-1:0] width_ff, height_ff;
   logic [DW-1:0] pw_ff, ph_ff;
   logic [2*DW-1:0] area_ff;
   logic [TW-1:0] total_ff;
   mpsra_pkg::token_type inject_ff, inject_in;

   logic [1:0]    res_status_ff;
   logic [mpsra_pkg::PIDX_W-1:0] res_page_ff;
   logic [mpsra_pkg::POS_W-1:0]  res_x_ff, res_y_ff;

   logic          rsp_valid_ff;
   logic [47:0]   rsp_data_ff;
   logic [1:0]    rsp_user_ff;

   logic [SW-1:0] pw_sum, ph_sum;
   logic          empty, too_big;
   logic          launch, finish, deliver;

   mpsra_pkg::token_type tok_link [MAX_PAGES+1];
   mpsra_pkg::token_type chain_end;

   // Padded size and the early checks.
   always_comb begin
      pw_sum = SW'(width_ff) + SW'({pad_ff, 1'b0});
      ph_sum = SW'(height_ff) + SW'({pad_ff, 1'b0});
      empty = (width_ff == '0) || (height_ff == '0);
      too_big = ({1'b0, pw_sum} > LIMIT) || ({1'b0, ph_sum} > LIMIT);
   end

   assign chain_end = tok_link[MAX_PAGES];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpsra_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = mpsra_pkg::ST_CHECK;
         end
         mpsra_pkg::ST_CHECK: begin
            state_in = (empty || too_big) ? mpsra_pkg::ST_HOLD : mpsra_pkg::ST_RUN;
         end
         mpsra_pkg::ST_RUN: begin
            if (chain_end.valid) state_in = mpsra_pkg::ST_HOLD;
         end
         mpsra_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) state_in = mpsra_pkg::ST_IDLE;
         end
         default: state_in = mpsra_pkg::ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_tready = 1'b0;
      launch = 1'b0;
      finish = 1'b0;
      deliver = 1'b0;
      case (state_ff)
         mpsra_pkg::ST_IDLE: req_tready = 1'b1;
         mpsra_pkg::ST_CHECK: launch = !empty && !too_big;
         mpsra_pkg::ST_RUN: finish = chain_end.valid;
         mpsra_pkg::ST_HOLD: deliver = !rsp_valid_ff || rsp_tready;
         default: req_tready = 1'b0;
      endcase
   end

   // Token sent into the first page cell.
   always_comb begin
      inject_in = '0;
      inject_in.valid = launch;
      inject_in.pw = DW'(pw_sum);
      inject_in.ph = DW'(ph_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpsra_pkg::ST_IDLE;
         pad_ff <= 4'd1;
         inject_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_tvalid) pad_ff <= csr_tdata[3:0];
         inject_ff <= inject_in;
         if (finish && chain_end.done) total_ff <= total_ff + area_ff[TW-1:0];
         if (deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         width_ff <= req_tdata[RW-1:0];
         height_ff <= req_tdata[2*RW-1:RW];
      end
      if (state_ff == mpsra_pkg::ST_CHECK) begin
         pw_ff <= DW'(pw_sum);
         ph_ff <= DW'(ph_sum);
         res_status_ff <= empty ? mpsra_pkg::STATUS_EMPTY : mpsra_pkg::STATUS_TOO_BIG;
         res_page_ff <= '0;
         res_x_ff <= '0;
         res_y_ff <= '0;
      end
      area_ff <= pw_ff * ph_ff;
      if (finish) begin
         res_status_ff <= chain_end.done ? mpsra_pkg::STATUS_PLACED
                                         : mpsra_pkg::STATUS_FULL;
         res_page_ff <= chain_end.page[mpsra_pkg::PIDX_W-1:0];
         res_x_ff <= chain_end.px;
         res_y_ff <= chain_end.py;
      end
      if (deliver) begin
         rsp_data_ff <= {1'b0, total_ff, res_y_ff, res_x_ff, res_page_ff};
         rsp_user_ff <= res_status_ff;
      end
   end

   // Row of page cells.
   assign tok_link[0] = inject_ff;

   for (genvar gi = 0; gi < MAX_PAGES; gi++) begin : g_page
      mpsra_cell #(
         .PAGE_SIZE(PAGE_SIZE),
         .INDEX(gi)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .pad(pad_ff),
         .tok_in(tok_link[gi]),
         .tok_out(tok_link[gi+1])
      );
   end

   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

// ===== hw/rtl/mpsra_checker.sv =====
module mpsra_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled result keeps its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A result that was not placed carries no page and no position.
   a_unplaced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != mpsra_pkg::STATUS_PLACED) |-> rsp_tdata[22:0] == 23'd0)
      else $error("unplaced result has a position");

   // Only one request is in progress: ready drops right after an item is taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   // The padding bit above the total is always zero.
   a_pad_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[47])
      else $error("result padding bit set");

endmodule

bind multi_page_shelf_rect_allocator mpsra_checker u_mpsra_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

// ===== dv/multi_page_shelf_rect_allocator_test.sv =====
module multi_page_shelf_rect_allocator_test;

   localparam int PAGE_SIZE = 1024;
   localparam int MAX_PAGES = 8;
   localparam int CLOCK_PERIOD = 20;
   localparam int RUN_LIMIT_CYCLES = 200000;
   localparam int PHASE_ITEMS = 270;
   localparam int ROW_SLOTS = 32;
   localparam int EXPECT_SLOTS = 4096;

   // One result as the block reports it.
   typedef struct packed {
      logic [1:0]                    status;
      logic [mpsra_pkg::PIDX_W-1:0]  page;
      logic [mpsra_pkg::POS_W-1:0]   x;
      logic [mpsra_pkg::POS_W-1:0]   y;
      logic [mpsra_pkg::TOTAL_W-1:0] total;
   } placement_type;

   // Rows of the directed table: a request checked by the predictor, a request
   // with its result typed in, or a write of the padding register.
   typedef enum logic [1:0] {
      ROW_RECT,
      ROW_KNOWN,
      ROW_PADDING
   } row_kind_type;

   typedef struct {
      row_kind_type  kind;
      int unsigned   w;
      int unsigned   h;
      placement_type want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [47:0]          rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 csr_tvalid = 1'b0;
   logic                 csr_tready;
   logic [7:0]           csr_tdata = '0;

   // Predictor state: one shelf per page plus the padding register.
   int unsigned          padding;
   int unsigned          cursor_x [MAX_PAGES];
   int unsigned          shelf_y [MAX_PAGES];
   int unsigned          shelf_h [MAX_PAGES];
   int unsigned          page_area [MAX_PAGES];
   int unsigned          open_pages;

   // Results still owed by the block, in order, and the directed table.
   placement_type        expected_items [EXPECT_SLOTS];
   int                   expect_wr = 0;
   int                   expect_rd = 0;
   stim_row_type         directed_rows [ROW_SLOTS];
   int                   row_count = 0;
   int                   mismatch_count = 0;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;

   multi_page_shelf_rect_allocator #(
      .PAGE_SIZE(PAGE_SIZE),
      .MAX_PAGES(MAX_PAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_tvalid(csr_tvalid),
      .csr_tready(csr_tready),
      .csr_tdata(csr_tdata)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // Try one page's shelf. A rectangle that overruns the shelf closes it, even
   // when the rectangle then does not fit below it either.
   function automatic bit try_shelf(input int unsigned p, input int unsigned pw,
                                    input int unsigned ph, output int unsigned px,
                                    output int unsigned py);
      px = 0;
      py = 0;
      if (cursor_x[p] + pw > PAGE_SIZE) begin
         cursor_x[p] = 0;
         shelf_y[p] = shelf_y[p] + shelf_h[p];
         shelf_h[p] = 0;
      end
      if (shelf_y[p] + ph > PAGE_SIZE) return 1'b0;
      px = cursor_x[p] + padding;
      py = shelf_y[p] + padding;
      cursor_x[p] = cursor_x[p] + pw;
      if (ph > shelf_h[p]) shelf_h[p] = ph;
      page_area[p] = page_area[p] + pw * ph;
      return 1'b1;
   endfunction

   // First-fit placement over the open pages, opening a new page when needed.
   function automatic placement_type place_rect(input int unsigned w, input int unsigned h);
      placement_type r;
      int unsigned   pw;
      int unsigned   ph;
      int unsigned   px;
      int unsigned   py;
      int unsigned   sum;
      bit            done;
      r = '0;
      px = 0;
      py = 0;
      sum = 0;
      if (w == 0 || h == 0) begin
         r.status = mpsra_pkg::STATUS_EMPTY;
      end else begin
         pw = w + 2 * padding;
         ph = h + 2 * padding;
         if (pw > PAGE_SIZE || ph > PAGE_SIZE) begin
            r.status = mpsra_pkg::STATUS_TOO_BIG;
         end else begin
            done = 1'b0;
            for (int unsigned i = 0; i < open_pages && !done; i++) begin
               if (try_shelf(i, pw, ph, px, py)) begin
                  r.page = mpsra_pkg::PIDX_W'(i);
                  done = 1'b1;
               end
            end
            if (!done) begin
               if (open_pages < MAX_PAGES) begin
                  cursor_x[open_pages] = 0;
                  shelf_y[open_pages] = 0;
                  shelf_h[open_pages] = 0;
                  page_area[open_pages] = 0;
                  void'(try_shelf(open_pages, pw, ph, px, py));
                  r.page = mpsra_pkg::PIDX_W'(open_pages);
                  open_pages = open_pages + 1;
               end else begin
                  r.status = mpsra_pkg::STATUS_FULL;
                  px = 0;
                  py = 0;
               end
            end
         end
      end
      for (int unsigned i = 0; i < open_pages; i++) sum = sum + page_area[i];
      r.x = mpsra_pkg::POS_W'(px);
      r.y = mpsra_pkg::POS_W'(py);
      r.total = mpsra_pkg::TOTAL_W'(sum);
      return r;
   endfunction

   task automatic add_row(input row_kind_type kind, input int unsigned w,
                          input int unsigned h,
                          input logic [1:0] status, input int unsigned page,
                          input int unsigned x, input int unsigned y,
                          input int unsigned total);
      stim_row_type row;
      row.kind = kind;
      row.w = w;
      row.h = h;
      row.want.status = status;
      row.want.page = mpsra_pkg::PIDX_W'(page);
      row.want.x = mpsra_pkg::POS_W'(x);
      row.want.y = mpsra_pkg::POS_W'(y);
      row.want.total = mpsra_pkg::TOTAL_W'(total);
      directed_rows[row_count] = row;
      row_count++;
   endtask

   // Offer one rectangle, with an occasional gap before it, and record what it
   // should produce once the block takes it.
   task automatic send_rect(input int unsigned w, input int unsigned h, input bit known,
                            input placement_type want);
      placement_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, mpsra_pkg::RECT_W'(h), mpsra_pkg::RECT_W'(w)};
      do @(posedge clock); while (!req_tready);
      predicted = place_rect(w, h);
      expected_items[expect_wr] = known ? want : predicted;
      expect_wr++;
   endtask

   // Padding changes only once the block has drained.
   task automatic set_padding(input int unsigned value);
      req_tvalid <= 1'b0;
      while (expect_rd != expect_wr) @(posedge clock);
      repeat (MAX_PAGES + 3) @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata <= {4'b0000, value[3:0]};
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      padding = value;
   endtask

   // Mostly small rectangles that pack onto shelves, with some wide, tall,
   // empty, oversized and fully random requests mixed in.
   task automatic random_rect(output int unsigned w, output int unsigned h);
      int unsigned pick;
      int unsigned first_big;
      pick = $urandom_range(99);
      first_big = PAGE_SIZE - 2 * padding + 1;
      if (pick < 80) begin
         w = $urandom_range(1, 128);
         h = $urandom_range(1, 64);
      end else if (pick < 84) begin
         w = $urandom_range(1, 1024);
         h = $urandom_range(1, 300);
      end else if (pick < 86) begin
         w = $urandom_range(1, 100);
         h = $urandom_range(1, 1024);
      end else if (pick < 90) begin
         w = $urandom_range(0, 2047);
         h = $urandom_range(0, 2047);
         if ($urandom_range(1)) w = 0;
         else h = 0;
      end else if (pick < 94) begin
         w = $urandom_range(first_big, 2047);
         h = $urandom_range(1, 2047);
         if ($urandom_range(1)) begin
            h = w;
            w = $urandom_range(1, 2047);
         end
      end else begin
         w = $urandom_range(0, 2047);
         h = $urandom_range(0, 2047);
      end
   endtask

   // Result side: random stalls, and each taken item is checked in order.
   always @(posedge clock) begin
      placement_type got;
      placement_type want;
      got.status = rsp_tuser;
      got.page = rsp_tdata[2:0];
      got.x = rsp_tdata[12:3];
      got.y = rsp_tdata[22:13];
      got.total = rsp_tdata[46:23];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expect_rd == expect_wr) begin
            if (mismatch_count < 10)
               $display("unexpected item: status %0d page %0d x %0d y %0d total %0d",
                        got.status, got.page, got.x, got.y, got.total);
            mismatch_count++;
         end else begin
            want = expected_items[expect_rd];
            expect_rd++;
            if (got.status !== want.status || got.page !== want.page ||
                got.x !== want.x || got.y !== want.y || got.total !== want.total) begin
               if (mismatch_count < 10)
                  $display({"mismatch: expected status %0d page %0d x %0d y %0d total %0d,",
                            " got status %0d page %0d x %0d y %0d total %0d"},
                           want.status, want.page, want.x, want.y, want.total,
                           got.status, got.page, got.x, got.y, got.total);
               mismatch_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Main sequence: directed table, three random phases, then a run of large
   // rectangles that opens every page and ends in all-full results.
   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned phase_pad;

      padding = 1;
      open_pages = 0;
      for (int i = 0; i < MAX_PAGES; i++) begin
         cursor_x[i] = 0;
         shelf_y[i] = 0;
         shelf_h[i] = 0;
         page_area[i] = 0;
      end

      // Padding is 1 after reset.
      add_row(ROW_KNOWN, 0, 0, mpsra_pkg::STATUS_EMPTY, 0, 0, 0, 0);
      add_row(ROW_KNOWN, 0, 1024, mpsra_pkg::STATUS_EMPTY, 0, 0, 0, 0);
      add_row(ROW_KNOWN, 2047, 0, mpsra_pkg::STATUS_EMPTY, 0, 0, 0, 0);
      add_row(ROW_KNOWN, 2047, 2047, mpsra_pkg::STATUS_TOO_BIG, 0, 0, 0, 0);
      add_row(ROW_KNOWN, 1023, 1, mpsra_pkg::STATUS_TOO_BIG, 0, 0, 0, 0);
      add_row(ROW_KNOWN, 1, 1023, mpsra_pkg::STATUS_TOO_BIG, 0, 0, 0, 0);
      add_row(ROW_KNOWN, 1022, 1022, mpsra_pkg::STATUS_PLACED, 0, 1, 1, 1048576);
      // The full first page fails, but its shelf is closed on the way.
      add_row(ROW_RECT, 1, 1, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 1, 1, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 1022, 1, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_PADDING, 15, 0, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 995, 10, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 994, 20, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 10, 994, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 0, 2047, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_PADDING, 0, 0, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 1024, 1, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 1, 1024, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 1025, 1, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 682, 1365, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 1365, 682, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 600, 600, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_PADDING, 1, 0, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 300, 200, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 511, 300, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);
      add_row(ROW_RECT, 3, 1000, mpsra_pkg::STATUS_PLACED, 0, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 12;
      recv_idle_pct = 62;
      for (int i = 0; i < row_count; i++) begin
         if (directed_rows[i].kind == ROW_PADDING)
            set_padding(directed_rows[i].w);
         else
            send_rect(directed_rows[i].w, directed_rows[i].h,
                      directed_rows[i].kind == ROW_KNOWN, directed_rows[i].want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         phase_pad = (phase == 0) ? 0 : (phase == 1) ? 15 : $urandom_range(1, 14);
         set_padding(phase_pad);
         send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 62 : 0;
         recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 12 : 0;
         repeat (PHASE_ITEMS) begin
            random_rect(w, h);
            send_rect(w, h, 1'b0, '0);
         end
      end

      // Each of these needs a page of its own, so the last ones find all full.
      repeat (12) send_rect(900, 900, 1'b0, '0);
      send_rect(1, 1, 1'b0, '0);
      send_rect(0, 0, 1'b0, '0);

      req_tvalid <= 1'b0;
      while (expect_rd != expect_wr) @(posedge clock);
      repeat (4 * (MAX_PAGES + 3)) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(CLOCK_PERIOD * RUN_LIMIT_CYCLES);
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/mpsra_pkg.sv
hw/rtl/mpsra_cell.sv
hw/rtl/multi_page_shelf_rect_allocator.sv
hw/rtl/mpsra_checker.sv
dv/multi_page_shelf_rect_allocator_test.sv
